FILE: hw/rtl/sbs_pkg.sv
// Package for the s-expression boundary scanner: form kinds, verdict codes,
// character codes and small byte classifiers.
// No dependencies; imported by every module of the scanner.
package sbs_pkg;

    // Width of the configured length limit.
    localparam int CFG_LEN_BITS = 24;

    // Length limit after reset.
    localparam logic [CFG_LEN_BITS-1:0] DEFAULT_MAX_LEN = CFG_LEN_BITS'(64 * 1024);

    // Kind of form that is currently open.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ATOM   = 2'd1,
        KIND_LIST   = 2'd2,
        KIND_STRING = 2'd3
    } form_kind_t;

    // Verdict given on the final byte of a scan.
    typedef enum logic [2:0] {
        VERDICT_PENDING    = 3'd0,
        VERDICT_OK         = 3'd1,
        VERDICT_INCOMPLETE = 3'd2,
        VERDICT_EMPTY      = 3'd3,
        VERDICT_TOO_LONG   = 3'd4
    } verdict_t;

    localparam int VERDICT_BITS = 3;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_QUOTE   = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    // White space between expressions.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_NEWLINE) ||
               (c == CHAR_TAB) || (c == CHAR_CR);
    endfunction

    // Bytes that end a bare atom.
    function automatic logic is_atom_end(input logic [7:0] c);
        return is_blank(c) || (c == CHAR_LPAREN) || (c == CHAR_RPAREN) ||
               (c == CHAR_SEMI);
    endfunction

endpackage

FILE: hw/rtl/sbs_scan_core.sv
// Scan state registers and the per-byte next-state and verdict logic.
// Depends on sbs_pkg; instantiated by sexp_boundary_scanner_core.
module sbs_scan_core
    import sbs_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int DEPTH_BITS    = 16,
    parameter int RESULT_BITS   = 3 * POSITION_BITS + DEPTH_BITS + 5 + VERDICT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic [7:0]               text_byte,
    input  logic                     is_last,
    input  logic [CFG_LEN_BITS-1:0]  max_len,
    output logic [RESULT_BITS-1:0]   result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX = '1;
    localparam int CMP_BITS = (POSITION_BITS > CFG_LEN_BITS) ? POSITION_BITS : CFG_LEN_BITS;

    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [POSITION_BITS-1:0] form_start_reg, form_start_next;
    logic [POSITION_BITS-1:0] done_start_reg, done_start_next;
    logic [POSITION_BITS-1:0] done_end_reg, done_end_next;
    logic [DEPTH_BITS-1:0]    depth_reg, depth_next;
    form_kind_t               kind_reg, kind_next;
    logic                     comment_reg, comment_next;
    logic                     escape_reg, escape_next;
    logic                     quote_reg, quote_next;

    // Scan one byte, close an atom on the final byte and judge the scan.
    always_comb begin
        logic [POSITION_BITS-1:0] cnt, cnt_inc, fs, ds, de, span_val;
        logic [DEPTH_BITS-1:0]    dp;
        form_kind_t               kd;
        logic                     cm, es, qt, rescan, open_form;
        verdict_t                 vd;

        cnt     = count_reg;
        fs      = form_start_reg;
        ds      = done_start_reg;
        de      = done_end_reg;
        dp      = depth_reg;
        kd      = kind_reg;
        cm      = comment_reg;
        es      = escape_reg;
        qt      = quote_reg;
        rescan  = 1'b0;
        cnt_inc = (count_reg == POS_MAX) ? POS_MAX : count_reg + 1'b1;

        // Dispatch on the open form.
        if (cm) begin
            if (text_byte == CHAR_NEWLINE) begin
                cm = 1'b0;
            end
        end else if (kd == KIND_LIST) begin
            // Inside a list the quote flag marks an embedded string.
            if (es) begin
                es = 1'b0;
            end else if (qt) begin
                if (text_byte == CHAR_BSLASH) begin
                    es = 1'b1;
                end else if (text_byte == CHAR_DQUOTE) begin
                    qt = 1'b0;
                end
            end else if (text_byte == CHAR_SEMI) begin
                cm = 1'b1;
            end else if (text_byte == CHAR_DQUOTE) begin
                qt = 1'b1;
            end else if (text_byte == CHAR_LPAREN) begin
                if (dp != DEPTH_MAX) begin
                    dp = dp + 1'b1;
                end
            end else if (text_byte == CHAR_RPAREN) begin
                if (dp != '0) begin
                    dp = dp - 1'b1;
                end
                if (dp == '0) begin
                    ds = fs;
                    de = cnt_inc;
                    fs = '0;
                    kd = KIND_NONE;
                    qt = 1'b0;
                end
            end
        end else if (kd == KIND_STRING) begin
            if (es) begin
                es = 1'b0;
            end else if (text_byte == CHAR_BSLASH) begin
                es = 1'b1;
            end else if (text_byte == CHAR_DQUOTE) begin
                ds = fs;
                de = cnt_inc;
                fs = '0;
                kd = KIND_NONE;
                qt = 1'b0;
                dp = '0;
            end
        end else if (kd == KIND_ATOM) begin
            // A delimiter ends the atom and is then scanned at top level.
            if (is_atom_end(text_byte)) begin
                ds     = fs;
                de     = count_reg;
                fs     = '0;
                kd     = KIND_NONE;
                qt     = 1'b0;
                dp     = '0;
                rescan = 1'b1;
            end
        end else begin
            rescan = 1'b1;
        end

        // Top-level handling of a byte outside any form.
        if (rescan && !is_blank(text_byte)) begin
            if (text_byte == CHAR_SEMI) begin
                cm = 1'b1;
            end else if (text_byte == CHAR_QUOTE) begin
                if (!qt) begin
                    fs = count_reg;
                end
                qt = 1'b1;
            end else begin
                if (!qt) begin
                    fs = count_reg;
                end
                if (text_byte == CHAR_LPAREN) begin
                    kd = KIND_LIST;
                    dp = DEPTH_BITS'(1);
                    qt = 1'b0;
                end else if (text_byte == CHAR_DQUOTE) begin
                    kd = KIND_STRING;
                    es = 1'b0;
                    qt = 1'b0;
                end else if (text_byte == CHAR_RPAREN) begin
                    // A stray close paren is an expression of its own, with any pending quote.
                    ds = fs;
                    de = cnt_inc;
                    fs = '0;
                    kd = KIND_NONE;
                    qt = 1'b0;
                    dp = '0;
                end else begin
                    kd = KIND_ATOM;
                    qt = 1'b0;
                end
            end
        end

        cnt = cnt_inc;

        // The final byte closes an open atom.
        if (is_last && (kd == KIND_ATOM)) begin
            ds = fs;
            de = cnt;
            fs = '0;
            kd = KIND_NONE;
            qt = 1'b0;
            dp = '0;
        end

        // Verdict: open forms first, then the last completed expression.
        open_form = (kd != KIND_NONE) || qt;
        if (open_form) begin
            span_val = (cnt >= fs) ? cnt - fs : '0;
        end else begin
            span_val = (de >= ds) ? de - ds : '0;
        end
        if (!is_last) begin
            vd = VERDICT_PENDING;
        end else if (open_form) begin
            vd = (CMP_BITS'(span_val) > CMP_BITS'(max_len)) ? VERDICT_TOO_LONG
                                                             : VERDICT_INCOMPLETE;
        end else if (de == '0) begin
            vd = VERDICT_EMPTY;
        end else if (CMP_BITS'(span_val) > CMP_BITS'(max_len)) begin
            vd = VERDICT_TOO_LONG;
        end else begin
            vd = VERDICT_OK;
        end

        result = {vd, de, ds, dp, es, cm, (qt && (kd != KIND_LIST)), kd, cnt};

        // The final byte clears the scan after its result is formed.
        if (is_last) begin
            count_next      = '0;
            form_start_next = '0;
            done_start_next = '0;
            done_end_next   = '0;
            depth_next      = '0;
            kind_next       = KIND_NONE;
            comment_next    = 1'b0;
            escape_next     = 1'b0;
            quote_next      = 1'b0;
        end else begin
            count_next      = cnt;
            form_start_next = fs;
            done_start_next = ds;
            done_end_next   = de;
            depth_next      = dp;
            kind_next       = kd;
            comment_next    = cm;
            escape_next     = es;
            quote_next      = qt;
        end
    end

    // Scan state, advanced once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            form_start_reg <= '0;
            done_start_reg <= '0;
            done_end_reg   <= '0;
            depth_reg      <= '0;
            kind_reg       <= KIND_NONE;
            comment_reg    <= 1'b0;
            escape_reg     <= 1'b0;
            quote_reg      <= 1'b0;
        end else if (step_en) begin
            count_reg      <= count_next;
            form_start_reg <= form_start_next;
            done_start_reg <= done_start_next;
            done_end_reg   <= done_end_next;
            depth_reg      <= depth_next;
            kind_reg       <= kind_next;
            comment_reg    <= comment_next;
            escape_reg     <= escape_next;
            quote_reg      <= quote_next;
        end
    end

endmodule

FILE: hw/rtl/sexp_boundary_scanner_core.sv
// Channel    | Direction | Beat content
// s_axis     | in        | tdata: text_byte; tlast: is_last
// m_axis     | out       | tdata: scan result fields, see port comment
// cfg        | in        | cfg_wr_data: max_expression_length
//
// One input beat is taken per cycle while the result stream is not stalled;
// the scan core forms the next scan state combinationally from the held beat,
// so the sustained rate is one byte per clock. A beat passes through the input
// register, then the result register, on its way to the result stream.
// aresetn is synchronous and active low; it clears the scan state, the valid
// flags of both beat registers and sets the length limit to 65536.
// A stalled result holds the output register; the input register still
// takes one more beat before s_tready drops.
//
// Top level of the s-expression boundary scanner.
// Depends on sbs_pkg and sbs_scan_core.
module sexp_boundary_scanner_core
    import sbs_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration: max_expression_length
    input  logic                    cfg_wr_en,
    input  logic [CFG_LEN_BITS-1:0] cfg_wr_data,
    // Input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,  // [7:0] text_byte
    input  logic                    s_tlast,  // is_last
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // From bit 0 up: position, open_kind, quote_pending, in_comment,
    // in_escape, nesting_depth, last_begin, last_finish, verdict, zero fill.
    output logic [((3 * POSITION_BITS + DEPTH_BITS + 5 + VERDICT_BITS + 7) / 8) * 8 - 1:0]
                                    m_tdata
);

    localparam int RESULT_BITS = 3 * POSITION_BITS + DEPTH_BITS + 5 + VERDICT_BITS;
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;
    logic                    out_valid_reg;
    logic [TDATA_BITS-1:0]   out_data_reg;
    logic [CFG_LEN_BITS-1:0] max_len_reg;
    logic                    advance;
    logic [RESULT_BITS-1:0]  result;

    // A held beat moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Length limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= DEFAULT_MAX_LEN;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Input beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sbs_scan_core #(
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS),
        .RESULT_BITS   (RESULT_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .text_byte (in_byte_reg),
        .is_last   (in_last_reg),
        .max_len   (max_len_reg),
        .result    (result)
    );

    // Result beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= TDATA_BITS'(result);
        end
    end

endmodule

FILE: hw/rtl/sbs_checker.sv
// Port-level checks for the s-expression boundary scanner, with the bind
// that attaches them to sexp_boundary_scanner_core. Depends on sbs_pkg.
module sbs_checker
    import sbs_pkg::*;
#(
    parameter int POSITION_BITS = 24,
    parameter int DEPTH_BITS    = 16
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [((3 * POSITION_BITS + DEPTH_BITS + 5 + VERDICT_BITS + 7) / 8) * 8 - 1:0]
                                   m_tdata
);

    localparam int KIND_LO   = POSITION_BITS;
    localparam int QUOTE_BIT = POSITION_BITS + 2;
    localparam int DEPTH_LO  = POSITION_BITS + 5;
    localparam int VERD_LO   = 3 * POSITION_BITS + DEPTH_BITS + 5;

    logic [POSITION_BITS-1:0] position;
    logic [1:0]               open_kind;
    logic [DEPTH_BITS-1:0]    depth;
    logic [VERDICT_BITS-1:0]  verdict;
    logic                     after_final_reg;

    assign position  = m_tdata[POSITION_BITS-1:0];
    assign open_kind = m_tdata[KIND_LO +: 2];
    assign depth     = m_tdata[DEPTH_LO +: DEPTH_BITS];
    assign verdict   = m_tdata[VERD_LO +: VERDICT_BITS];

    // Set when a final beat leaves, cleared when a beat that is not final leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_final_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            after_final_reg <= (verdict != VERDICT_PENDING);
        end
    end

    // No result beat straight after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // The beat after a final one starts a fresh scan at position one.
    a_fresh_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && after_final_reg |-> position == POSITION_BITS'(1))
        else $error("scan not cleared after final beat");

    // Depth is reported only while a list is open, and a quote never is.
    a_depth_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (depth == '0) || (open_kind == KIND_LIST))
        else $error("depth reported outside a list");

    a_quote_list: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (open_kind == KIND_LIST) |-> !m_tdata[QUOTE_BIT])
        else $error("quote pending reported inside a list");

endmodule

bind sexp_boundary_scanner_core sbs_checker #(
    .POSITION_BITS (POSITION_BITS),
    .DEPTH_BITS    (DEPTH_BITS)
) u_sbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
